[rtl/core/fasm_pkg.sv]
// Shared constants and helper functions for the float add/sub/mul unit.
package fasm_pkg;

  localparam int unsigned FuncW = 2;
  localparam int unsigned WordW = 32;
  localparam int unsigned FracW = 23;
  localparam int unsigned ExpW = 8;
  localparam int unsigned SigW = 24;
  localparam int unsigned ExpBias = 127;
  localparam int unsigned MaxShift = 31;
  localparam int unsigned SumW = 25;

  // Operation codes.
  localparam logic [FuncW-1:0] FuncAdd = 2'd0;
  localparam logic [FuncW-1:0] FuncSub = 2'd1;
  localparam logic [FuncW-1:0] FuncMul = 2'd2;

  // Position of the leading one in a 23-bit fraction, as a leading-zero count (23 when zero).
  function automatic logic [4:0] lzc23(input logic [FracW-1:0] f);
    logic [4:0] n;
    n = 5'd23;
    for (int i = 0; i < FracW; i++) begin
      if (f[i]) begin
        n = 5'(FracW - 1 - i);
      end
    end
    return n;
  endfunction

  // Leading-zero count of a 25-bit sum from bit 24 (25 when zero).
  function automatic logic [4:0] lzc25(input logic [SumW-1:0] f);
    logic [4:0] n;
    n = 5'd25;
    for (int i = 0; i < SumW; i++) begin
      if (f[i]) begin
        n = 5'(SumW - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

[rtl/core/fasm_add_path.sv]
// Three-stage add/subtract datapath: align, add and count, normalize.
module fasm_add_path (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] res_o
);
  import fasm_pkg::*;

  // Stage 1 registers.
  logic            s_q, s_d, same_q, same_d, bsub_q, bsub_d;
  logic [ExpW-1:0] e_q, e_d;
  logic [SigW-1:0] big_q, big_d, sml_q, sml_d;
  // Stage 2 registers.
  logic            s2_q, bsub2_q;
  logic [ExpW-1:0] e2_q;
  logic [SumW-1:0] sum_q, sum_d;
  logic [4:0]      k_q, k_d;

  logic [ExpW-1:0]  ea, eb, sh;
  logic [FracW-1:0] ma, mb;
  logic [SigW-1:0]  siga, sigb, pre;
  logic             a_big;

  // Order the operands and align the smaller one.
  always_comb begin
    ea = a_i[30:23];
    eb = b_i[30:23];
    ma = a_i[22:0];
    mb = b_i[22:0];
    siga = {ea != '0, ma};
    sigb = {eb != '0, mb};
    a_big = (ea > eb) || ((ea == eb) && (ma >= mb));
    s_d = a_big ? a_i[31] : b_i[31];
    e_d = a_big ? ea : eb;
    big_d = a_big ? siga : sigb;
    pre = a_big ? sigb : siga;
    sh = a_big ? (ea - eb) : (eb - ea);
    sml_d = (sh > 8'(MaxShift)) ? '0 : (pre >> sh);
    same_d = a_i[31] == b_i[31];
    bsub_d = (ea == '0) && (eb == '0);
  end

  // Add or subtract and find the leading one.
  always_comb begin
    sum_d = same_q ? ({1'b0, big_q} + {1'b0, sml_q}) : ({1'b0, big_q} - {1'b0, sml_q});
    k_d = lzc25(sum_d);
  end

  // Normalize and pack. A carry out of exponent 255 runs on into the sign bit.
  logic [31:0] res;
  logic [SumW-1:0] shl;
  always_comb begin
    shl = sum_q << (k_q - 5'd1);
    if (k_q == 5'd25) begin
      res = '0;
    end else if (k_q == 5'd0) begin
      res = {s2_q, 31'b0} + ({23'b0, {1'b0, e2_q} + 9'd1} << 23) + {9'b0, sum_q[23:1]};
    end else if (k_q == 5'd1) begin
      res = {s2_q, 31'b0} + ({24'b0, bsub2_q ? e2_q + 8'd1 : e2_q} << 23) + {9'b0, sum_q[22:0]};
    end else if ({3'b0, e2_q} < {6'b0, k_q} - 11'd1) begin
      res = '0;
    end else begin
      res = {s2_q, 31'b0} + ({24'b0, e2_q + 8'd1 - {3'b0, k_q}} << 23) + {9'b0, shl[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d;
      same_q <= same_d;
      bsub_q <= bsub_d;
      e_q <= e_d;
      big_q <= big_d;
      sml_q <= sml_d;
      s2_q <= s_q;
      bsub2_q <= bsub_q;
      e2_q <= e_q;
      sum_q <= sum_d;
      k_q <= k_d;
      res_o <= res;
    end
  end

endmodule

[rtl/core/fasm_mul_path.sv]
// Three-stage multiply datapath: prenormalize, multiply, pack.
module fasm_mul_path (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] res_o
);
  import fasm_pkg::*;

  logic            s_q, s2_q, z_q, z2_q;
  logic [9:0]      e_q, e2_q;
  logic [SigW-1:0] sa_q, sb_q;
  logic [47:0]     p_q;

  logic [4:0]      lza, lzb;
  logic [SigW-1:0] sa, sb;
  logic [9:0]      e;
  logic            z;

  // Prenormalize subnormal operands and form the exponent.
  always_comb begin
    lza = (a_i[30:23] == '0) ? lzc23(a_i[22:0]) : 5'd0;
    lzb = (b_i[30:23] == '0) ? lzc23(b_i[22:0]) : 5'd0;
    sa = (a_i[30:23] == '0) ? 24'({a_i[22:0], 1'b0} << lza) : {1'b1, a_i[22:0]};
    sb = (b_i[30:23] == '0) ? 24'({b_i[22:0], 1'b0} << lzb) : {1'b1, b_i[22:0]};
    e = {2'b0, a_i[30:23]} + {2'b0, b_i[30:23]} - 10'(ExpBias) - {5'b0, lza} - {5'b0, lzb};
    z = (lza == 5'd23) || (lzb == 5'd23) || e[9];
  end

  // Pack the product.
  logic [31:0] res;
  always_comb begin
    if (z2_q) begin
      res = '0;
    end else if (p_q[47]) begin
      res = {s2_q, 31'b0} + ({24'b0, e2_q[7:0]} + 32'd1 << 23) + {9'b0, p_q[46:24]};
    end else if (e2_q == '0) begin
      res = {s2_q, 31'b0} + {9'b0, p_q[46:24]};
    end else begin
      res = {s2_q, 31'b0} + ({24'b0, e2_q[7:0]} << 23) + {9'b0, p_q[45:23]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= a_i[31] ^ b_i[31];
      z_q <= z;
      e_q <= e;
      sa_q <= sa;
      sb_q <= sb;
      s2_q <= s_q;
      z2_q <= z_q;
      e2_q <= e_q;
      p_q <= sa_q * sb_q;
      res_o <= res;
    end
  end

endmodule

[rtl/core/float32_add_sub_mul_unit.sv]
// Top level of the single-precision add/subtract/multiply unit.
// Usage:
//   Input channel: valid_i/ready_o with func_i, operand_a_i, operand_b_i.
//   func 0 adds, 1 subtracts (a minus b), 2 or 3 multiplies.
//   Output channel: valid_o/ready_i with result_word_o.
//   Results are truncated, with no NaN or infinity handling; underflow gives +0.
// Timing:
//   Three register stages; an accepted item moves through the stage-one,
//   stage-two and output registers, and its result is held there until
//   ready_i takes it. One item per cycle is accepted when the output is taken.
//   The depth is set by align/add/normalize and prenormalize/multiply/pack.
// Reset clears all stage valid bits; no result is pending after reset.
// Stall: the whole pipeline holds while the final result waits, and the
// input is not ready then; bubbles in earlier stages do not close up.
module float32_add_sub_mul_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] result_word_o
);
  import fasm_pkg::*;

  logic [2:0] v_q;
  logic [1:0] m_q;
  logic       en;
  logic [31:0] b_eff, add_res, mul_res;

  // The pipeline moves as one whenever the last stage is free.
  assign en = !v_q[2] || ready_i;
  assign ready_o = en;
  assign valid_o = v_q[2];
  assign b_eff = (func_i == FuncSub) ? (operand_b_i ^ 32'h8000_0000) : operand_b_i;

  fasm_add_path u_add (
    .clk_i(clk_i), .en_i(en), .a_i(operand_a_i), .b_i(b_eff), .res_o(add_res)
  );
  fasm_mul_path u_mul (
    .clk_i(clk_i), .en_i(en), .a_i(operand_a_i), .b_i(operand_b_i), .res_o(mul_res)
  );

  // Select per item by the multiply flag carried with it.
  logic sel_q;
  assign result_word_o = sel_q ? mul_res : add_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      m_q <= '0;
      sel_q <= 1'b0;
    end else if (en) begin
      v_q <= {v_q[1:0], valid_i};
      m_q <= {m_q[0], func_i[1]};
      sel_q <= m_q[1];
    end
  end

endmodule

[tb/float32_add_sub_mul_unit_tb.sv]
// Self-checking testbench for the truncating single-precision add/subtract/multiply unit.
module float32_add_sub_mul_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fasm_pkg::*;

  // Scoreboard: computes each expected word and holds them in order.
  class fp_scoreboard;
    logic [31:0] pending_words[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Significand add/subtract with leading-one normalization.
    function automatic logic [31:0] add_words(logic [31:0] a, logic [31:0] b);
      logic [7:0] ea, eb;
      logic [22:0] ma, mb;
      logic sgn, same_sign, both_sub;
      logic [31:0] e, big, sml, shift, sum;
      ea = a[30:23]; eb = b[30:23]; ma = a[22:0]; mb = b[22:0];
      both_sub = (ea == 0) && (eb == 0);
      same_sign = (a[31] == b[31]);
      if (ea > eb || (ea == eb && ma >= mb)) begin
        sgn = a[31]; e = ea;
        big = (ea == 0) ? {9'd0, ma} : {9'd1, ma};
        sml = (eb == 0) ? {9'd0, mb} : {9'd1, mb};
        shift = ea - eb;
      end else begin
        sgn = b[31]; e = eb;
        big = (eb == 0) ? {9'd0, mb} : {9'd1, mb};
        sml = (ea == 0) ? {9'd0, ma} : {9'd1, ma};
        shift = eb - ea;
      end
      sml = (shift <= 31) ? (sml >> shift) : 32'd0;
      sum = (same_sign ? big + sml : big - sml) & 32'h1FF_FFFF;
      for (int k = 0; k <= 24; k++) begin
        if (sum[24-k]) begin
          if (k == 0) return ({31'd0, sgn} << 31) + ((e + 1) << 23) + ((sum >> 1) & 32'h7F_FFFF);
          if (k == 1) return ({31'd0, sgn} << 31) + ((both_sub ? e + 1 : e) << 23)
                             + (sum & 32'h7F_FFFF);
          if (e < k - 1) return 32'd0;
          return ({31'd0, sgn} << 31) + ((e + 1 - k) << 23)
                 + ((sum & ((32'd1 << (24 - k)) - 1)) << (k - 1));
        end
      end
      return 32'd0;
    endfunction

    // Leading-zero count of a fraction and its normalized significand.
    function automatic void norm_frac(logic [22:0] f, output int lz, output logic [23:0] sig);
      lz = 23; sig = 0;
      for (int k = 22; k >= 0; k--) begin
        if (f[22-k]) begin
          lz = k;
          sig = 24'(f << (k + 1));
        end
      end
    endfunction

    // Truncating multiply with subnormal prenormalization.
    function automatic logic [31:0] mul_words(logic [31:0] a, logic [31:0] b);
      logic sgn;
      int lza, lzb, e;
      logic [23:0] sa, sb;
      logic [47:0] prod;
      sgn = a[31] ^ b[31];
      if (a[30:23] == 0) norm_frac(a[22:0], lza, sa);
      else begin lza = 0; sa = {1'b1, a[22:0]}; end
      if (b[30:23] == 0) norm_frac(b[22:0], lzb, sb);
      else begin lzb = 0; sb = {1'b1, b[22:0]}; end
      e = int'(a[30:23]) + int'(b[30:23]) - int'(ExpBias) - lza - lzb;
      if (lza == 23 || lzb == 23 || e < 0) return 32'd0;
      prod = sa * sb;
      if (prod[47]) return ({31'd0, sgn} << 31) + ((32'(e & 255) + 1) << 23)
                           + {9'd0, prod[46:24]};
      if (e == 0) return ({31'd0, sgn} << 31) + {9'd0, prod[46:24]};
      return ({31'd0, sgn} << 31) + (32'(e & 255) << 23) + {9'd0, prod[45:23]};
    endfunction

    function void note_item(logic [1:0] fn, logic [31:0] a, logic [31:0] b);
      logic [31:0] r;
      if (fn[1]) r = mul_words(a, b);
      else if (fn == FuncSub) r = add_words(a, b ^ 32'h8000_0000);
      else r = add_words(a, b);
      pending_words.push_back(r);
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result_word %h", $time, got);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got !== want) begin
        $display("%0t: result_word expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic ready_o;
  logic [1:0] func_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic valid_o;
  logic ready_i = 1'b0;
  logic [31:0] result_word_o;

  fp_scoreboard fp_sb = new();
  bit feed_done = 1'b0;
  bit long_hold = 1'b0;

  float32_add_sub_mul_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  // Drive one item and wait until it is taken; valid drops only for a gap.
  task automatic send_item(logic [1:0] fn, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    func_i <= fn;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (!ready_o);
    fp_sb.note_item(fn, a, b);
  endtask

  // Random operand, often with a zero, maximum or near-bias exponent or an extreme fraction.
  function automatic logic [31:0] pick_operand();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 5))
      0: w[30:23] = 8'd0;
      1: w[30:23] = 8'd255;
      2: w[30:23] = 8'($urandom_range(120, 134));
      3: w[22:0] = $urandom_range(0, 1) ? 23'd0 : 23'h7F_FFFF;
      default: ;
    endcase
    return w;
  endfunction

  // Stimulus.
  initial begin
    logic [31:0] a, b;
    logic [1:0] fn;
    logic [31:0] corner[8] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                               32'h0000_0001, 32'h007F_FFFF, 32'h3F80_0000, 32'h7F7F_FFFF};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: extremes, cancellation, huge shifts, subnormals, overflow, func 3.
    for (int i = 0; i < 8; i++) send_item(FuncAdd, corner[i], corner[7-i]);
    for (int i = 0; i < 6; i++) send_item(FuncSub, corner[i], corner[i]);
    send_item(FuncAdd, 32'h7F00_0000, 32'h0000_0001);
    for (int i = 0; i < 8; i++) send_item(FuncMul, corner[i], corner[(i+3)%8]);
    send_item(FuncMul, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
    send_item(2'd3, 32'h4000_0000, 32'h4040_0000);
    for (int n = 0; n < 950; n++) begin
      if (n == 300) begin
        // Pause until every result has drained.
        valid_i <= 1'b0;
        wait (fp_sb.pending_words.size() == 0);
        @(posedge clk_i);
      end
      if (n == 500) long_hold = 1'b1;
      fn = 2'($urandom_range(0, 3));
      a = pick_operand();
      b = $urandom_range(0, 2) == 0 ? (a ^ (32'($urandom_range(0, 1)) << 31)) : pick_operand();
      send_item(fn, a, b);
    end
    valid_i <= 1'b0;
    feed_done = 1'b1;
  end

  // Receiver with random stalls and one long hold-off.
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (valid_o && ready_i) fp_sb.check_result(result_word_o);
      if (long_hold) begin
        long_hold = 1'b0;
        ready_i <= 1'b0;
        repeat (60) @(posedge clk_i);
      end
      if (!ready_i || !valid_o) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
        if (gap == 0 || !valid_o) ready_i <= (gap == 0);
        else begin
          ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
          ready_i <= 1'b1;
        end
      end
    end
  end

  // End of run.
  initial begin
    wait (feed_done);
    wait (fp_sb.pending_words.size() == 0);
    repeat (20) @(posedge clk_i);
    if (fp_sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
